// ===== sv/bss_pkg.sv =====
// Shared types, constants and codes for the bounded set store.
`default_nettype none
package bss_pkg;

   // Default sizing
   localparam int CAPACITY    = 128;
   localparam int VALUE_WIDTH = 32;

   // Request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [1:0] status;
      logic [7:0] count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/bss_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module bss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/bss_engine.sv =====
// Request sequencer: linear search of the store, then insert, remove or query.
`default_nettype none
module bss_engine #(
   parameter int CAPACITY    = bss_pkg::CAPACITY,
   parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire bss_pkg::req_type            req_word,
   output logic                             rd_en,
   output logic [$clog2(CAPACITY)-1:0]      rd_addr,
   input  wire logic [VALUE_WIDTH-1:0]      rd_data,
   output logic                             wr_en,
   output logic [$clog2(CAPACITY)-1:0]      wr_addr,
   output logic [VALUE_WIDTH-1:0]           wr_data,
   output logic                             done_valid,
   input  wire logic                        done_ready,
   output bss_pkg::rsp_type                 done_word
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_MOVE,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic                   hit_ff, hit_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   found_ff, found_in;
   logic [1:0]             status_ff, status_in;

   logic [63:0]            value_wide;
   logic [VALUE_WIDTH-1:0] req_key;
   logic [CNT_W-1:0]       last;
   logic                   at_last;
   logic                   full;
   logic [CNT_W+7:0]       count_wide;

   // Drop value bits above the element width
   assign value_wide = {32'd0, req_word.value};
   assign req_key    = value_wide[VALUE_WIDTH-1:0];

   assign last    = count_ff - CNT_W'(1);
   assign at_last = (CNT_W'(idx_ff) == last);
   assign full    = (count_ff >= CNT_W'(CAPACITY));

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);

   // Response carries the low byte of the count
   assign count_wide       = {8'd0, count_ff};
   assign done_word.found  = found_ff;
   assign done_word.status = status_ff;
   assign done_word.count  = count_wide[7:0];

   // Next state, memory control and result
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      status_in = status_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_word.opcode;
               key_in = req_key;
               idx_in = '0;
               if (count_ff == '0) begin
                  hit_in   = 1'b0;
                  state_in = S_RESOLVE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_SCAN;
               end
            end
         end

         // One stored entry per cycle; stop on a match or at the last entry
         S_SCAN: begin
            if (rd_data == key_ff) begin
               hit_in   = 1'b1;
               state_in = S_RESOLVE;
            end else if (at_last) begin
               hit_in   = 1'b0;
               state_in = S_RESOLVE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
            end
         end

         S_RESOLVE: begin
            found_in  = hit_ff;
            status_in = bss_pkg::ST_DONE;
            state_in  = S_DONE;
            if (op_ff == bss_pkg::OP_INSERT) begin
               if (hit_ff) begin
                  status_in = bss_pkg::ST_DUP;
               end else if (full) begin
                  status_in = bss_pkg::ST_FULL;
               end else begin
                  // Append at the tail
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (op_ff == bss_pkg::OP_REMOVE) begin
               if (!hit_ff) begin
                  status_in = bss_pkg::ST_ABSENT;
               end else if (at_last) begin
                  count_in = last;
               end else begin
                  // Fetch the tail entry to fill the hole
                  rd_en    = 1'b1;
                  rd_addr  = last[AW-1:0];
                  state_in = S_MOVE;
               end
            end
         end

         // Write the tail entry into the freed slot
         S_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            count_in = last;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("occupancy moved by more than one");

   a_idle_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_SCAN) |=> $stable(count_ff))
      else $error("occupancy changed outside update");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      done_valid |->
         ((status_ff == bss_pkg::ST_DUP && found_ff) ||
          (status_ff == bss_pkg::ST_FULL && !found_ff) ||
          (status_ff == bss_pkg::ST_ABSENT && !found_ff) ||
          status_ff == bss_pkg::ST_DONE))
      else $error("status disagrees with found flag");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> 1'b0)
      else $error("store read and written in one cycle");
`endif

endmodule
`default_nettype wire

// ===== sv/bounded_set_store_top.sv =====
// Top level of the bounded set store: sequencer, element memory, response register.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | req_word (opcode, value)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_word (found, status, count)
//
// A request searches the stored entries up to a match, or all of them when the value is
// absent; a remove that moves the tail entry adds a move step before the response.
// The search reads the element memory one entry per cycle through its single read port.
// Reset clears the occupancy count, the sequencer state and the response valid flag;
// memory contents need no clearing. A waiting response holds the sequencer in its final
// state; one more request is taken while the response register is still full.
`default_nettype none
module bounded_set_store_top #(
   parameter int CAPACITY    = bss_pkg::CAPACITY,
   parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bss_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bss_pkg::rsp_type      rsp_word
);

   localparam int AW = $clog2(CAPACITY);

   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   done_valid;
   logic                   done_ready;
   bss_pkg::rsp_type       done_word;

   logic                   rsp_valid_ff;
   bss_pkg::rsp_type       rsp_word_ff;

   bss_engine #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_word  (done_word)
   );

   bss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load when empty or being drained
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && done_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_word_ff <= done_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire
